### design/cll_pkg.sv
// shared constants, types and helpers for the cursor linked list engine
`default_nettype none
package cll_pkg;

    localparam int NODE_SLOTS = 64;
    localparam int DATA_WIDTH = 16;
    localparam int SLOT_W     = $clog2(NODE_SLOTS);
    localparam int POS_W      = 6;
    localparam int CNT_W      = 6;

    localparam logic [SLOT_W-1:0] FREE_HEAD = '0;
    localparam logic [SLOT_W-1:0] LIST_HEAD = SLOT_W'(NODE_SLOTS - 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [SLOT_W-1:0] data;
    } link_wr_t;

    // link held by a slot right after reset: free chain in order, both chains end in 0
    function automatic logic [SLOT_W-1:0] reset_link(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] nxt;
        nxt = slot + SLOT_W'(1);
        return (slot < SLOT_W'(NODE_SLOTS - 2)) ? nxt : '0;
    endfunction

endpackage
`default_nettype wire

### design/cll_link_store.sv
// link memory with per-slot written flags so unwritten slots read their reset link
`default_nettype none
module cll_link_store (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cll_pkg::link_wr_t          wr,
    input  wire logic [cll_pkg::SLOT_W-1:0] rd_addr,
    output logic      [cll_pkg::SLOT_W-1:0] rd_data
);
    import cll_pkg::*;

    logic [SLOT_W-1:0]     link_mem [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] written_reg;
    logic [SLOT_W-1:0]     rdata_reg;
    logic [SLOT_W-1:0]     raddr_reg;
    logic                  rwritten_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            link_mem[wr.addr] <= wr.data;
        end
        rdata_reg    <= link_mem[rd_addr];
        raddr_reg    <= rd_addr;
        rwritten_reg <= written_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr.en) begin
            written_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = rwritten_reg ? rdata_reg : reset_link(raddr_reg);

endmodule
`default_nettype wire

### design/cursor_linked_list_engine_unit.sv
// top level of the cursor linked list engine: request sequencer and node value store
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  request | s_valid s_ready s_mode s_position s_value | in
//  answer  | m_valid m_ready m_status m_read_value     | out
//          | m_list_length                           |
//
// one request at a time; the walk follows one link per cycle through the link memory
// insert takes a slot off the free chain, delete hands its victim back to it, read
// fetches the node value; a rejected request or full store goes to the answer directly
// reset is synchronous; the link memory needs no clearing pass, written flags cover it
// a new word is taken while the previous answer still waits on m_ready
`default_nettype none
module cursor_linked_list_engine_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_mode,
    input  wire logic [cll_pkg::POS_W-1:0]      s_position,
    input  wire logic [cll_pkg::DATA_WIDTH-1:0] s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [1:0]                     m_status,
    output logic      [cll_pkg::DATA_WIDTH-1:0] m_read_value,
    output logic      [cll_pkg::CNT_W-1:0]      m_list_length
);
    import cll_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_FREE,
        ST_INS_FREE2,
        ST_WALK,
        ST_INS_LINK,
        ST_DEL_A,
        ST_DEL_B,
        ST_DEL_C,
        ST_RD_WAIT,
        ST_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            mode_reg, mode_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [POS_W-1:0]      steps_reg, steps_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [SLOT_W-1:0]     victim_reg, victim_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0] res_rd_reg, res_rd_next;
    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_status_reg, m_status_next;
    logic [DATA_WIDTH-1:0] m_rd_reg, m_rd_next;
    logic [CNT_W-1:0]      m_len_reg, m_len_next;

    link_wr_t              link_wr;
    logic [SLOT_W-1:0]     link_raddr;
    logic [SLOT_W-1:0]     link_rd;

    logic [DATA_WIDTH-1:0] val_mem [NODE_SLOTS];
    logic [DATA_WIDTH-1:0] val_q_reg;
    logic                  val_we;

    logic [POS_W:0]        pos_ext;
    logic [POS_W:0]        cnt_ext;
    logic                  pos_nonzero;
    logic                  ins_ok;
    logic                  acc_ok;

    cll_link_store u_links (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (link_wr),
        .rd_addr (link_raddr),
        .rd_data (link_rd)
    );

    // node values: written once per insert, read at the walk's end for a read
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[slot_reg] <= val_reg;
        end
        val_q_reg <= val_mem[cur_reg];
    end

    assign pos_ext     = {1'b0, s_position};
    assign cnt_ext     = (POS_W + 1)'(count_reg);
    assign pos_nonzero = (s_position != '0);
    assign ins_ok      = pos_nonzero && (pos_ext <= cnt_ext + (POS_W + 1)'(1));
    assign acc_ok      = pos_nonzero && (pos_ext <= cnt_ext);

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        slot_next       = slot_reg;
        victim_next     = victim_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_rd_next       = m_rd_reg;
        m_len_next      = m_len_reg;
        link_wr         = '0;
        link_raddr      = cur_reg;
        val_we          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next       = s_mode;
                    val_next        = s_value;
                    res_rd_next     = '0;
                    res_status_next = STAT_RANGE;
                    cur_next        = LIST_HEAD;
                    state_next      = ST_RESP;
                    case (s_mode)
                        MODE_INSERT: begin
                            if (ins_ok) begin
                                link_raddr = FREE_HEAD;
                                steps_next = s_position - POS_W'(1);
                                state_next = ST_INS_FREE;
                            end
                        end
                        MODE_DELETE: begin
                            if (acc_ok) begin
                                link_raddr = LIST_HEAD;
                                steps_next = s_position - POS_W'(1);
                                state_next = ST_WALK;
                            end
                        end
                        MODE_READ: begin
                            if (acc_ok) begin
                                link_raddr = LIST_HEAD;
                                steps_next = s_position;
                                state_next = ST_WALK;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_INS_FREE: begin
                // link_rd is the head of the free chain
                if (link_rd == FREE_HEAD) begin
                    res_status_next = STAT_FULL;
                    state_next      = ST_RESP;
                end else begin
                    slot_next  = link_rd;
                    link_raddr = link_rd;
                    state_next = ST_INS_FREE2;
                end
            end
            ST_INS_FREE2: begin
                // unhook the slot from the free chain and fill it
                link_wr    = '{en: 1'b1, addr: FREE_HEAD, data: link_rd};
                val_we     = 1'b1;
                link_raddr = LIST_HEAD;
                cur_next   = LIST_HEAD;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (steps_reg == '0) begin
                    // cur_reg is the target, link_rd its successor
                    case (mode_reg)
                        MODE_INSERT: begin
                            link_wr    = '{en: 1'b1, addr: slot_reg, data: link_rd};
                            state_next = ST_INS_LINK;
                        end
                        MODE_DELETE: begin
                            if (link_rd == FREE_HEAD) begin
                                state_next = ST_RESP;
                            end else begin
                                victim_next = link_rd;
                                link_raddr  = link_rd;
                                state_next  = ST_DEL_A;
                            end
                        end
                        default: begin
                            state_next = ST_RD_WAIT;
                        end
                    endcase
                end else begin
                    cur_next   = link_rd;
                    link_raddr = link_rd;
                    steps_next = steps_reg - POS_W'(1);
                end
            end
            ST_INS_LINK: begin
                link_wr         = '{en: 1'b1, addr: cur_reg, data: slot_reg};
                count_next      = count_reg + CNT_W'(1);
                res_status_next = STAT_DONE;
                state_next      = ST_RESP;
            end
            ST_DEL_A: begin
                // bypass the victim, then fetch the free head
                link_wr    = '{en: 1'b1, addr: cur_reg, data: link_rd};
                link_raddr = FREE_HEAD;
                state_next = ST_DEL_B;
            end
            ST_DEL_B: begin
                link_wr    = '{en: 1'b1, addr: victim_reg, data: link_rd};
                state_next = ST_DEL_C;
            end
            ST_DEL_C: begin
                link_wr         = '{en: 1'b1, addr: FREE_HEAD, data: victim_reg};
                count_next      = count_reg - CNT_W'(1);
                res_status_next = STAT_DONE;
                state_next      = ST_RESP;
            end
            ST_RD_WAIT: begin
                res_rd_next     = val_q_reg;
                res_status_next = STAT_DONE;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_rd_next     = res_rd_reg;
                    m_len_next    = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg       <= mode_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        slot_reg       <= slot_next;
        victim_reg     <= victim_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        m_status_reg   <= m_status_next;
        m_rd_reg       <= m_rd_next;
        m_len_reg      <= m_len_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_rd_reg;
    assign m_list_length = m_len_reg;

    // no link is rewritten while the walk is following the chain
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && steps_reg != '0) |-> !link_wr.en)
        else $error("link write during walk");

    // the list never outgrows the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(NODE_SLOTS - 2))
        else $error("entry count beyond capacity");

    // one request changes the length by at most one
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + CNT_W'(1)) ||
                 (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    // the sequencer is busy right after taking a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while busy");

endmodule
`default_nettype wire
